// ----- hdl/lli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lli_pkg
// Shared types and constants of the line intersection block.
// ----------------------------------------------------------------------------
package lli_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned SNAP_W         = 63;
  localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(1);

  typedef enum logic [1:0] {
    OUT_SINGLE     = 2'd0,
    OUT_COINCIDENT = 2'd1,
    OUT_PARALLEL   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [31:0] line_a_start_x;
    logic signed [31:0] line_a_start_y;
    logic signed [31:0] line_a_end_x;
    logic signed [31:0] line_a_end_y;
    logic signed [31:0] line_b_start_x;
    logic signed [31:0] line_b_start_y;
    logic signed [31:0] line_b_end_x;
    logic signed [31:0] line_b_end_y;
  } lli_in_t;

  typedef struct packed {
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    outcome_e           outcome;
    logic               clipped;
  } lli_out_t;

endpackage
`default_nettype wire

// ----- hdl/line_line_intersection.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while busy is low; the divider retires
// one quotient bit per stage, COORD_BITS stages per axis, both axes in parallel.
// busy rises only if the front-to-back queue is full; the receiver cannot stall.
// Reset clears all valid flags and the queue and sets snap_q to 1.
// ----------------------------------------------------------------------------
// line_line_intersection
// Intersection point of two lines given by two Q16.16 points each.
// ----------------------------------------------------------------------------
module line_line_intersection import lli_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire lli_in_t           cmd_i,
  input  wire logic              cfg_we_i,
  input  wire logic [SNAP_W-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output lli_out_t               result_o
);

  localparam int unsigned JW = 8 * COORD_BITS + 10;

  logic [SNAP_W-1:0] snap_q;
  logic              push, q_full, q_empty;
  logic [JW-1:0]     job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= SNAP_RESET;
    end else if (cfg_we_i) begin
      snap_q <= cfg_wdata_i;
    end
  end

  lli_front #(.CoordBits(COORD_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .snap_i   (snap_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job_in),
    .busy_o   (busy)
  );

  lli_queue #(.Width(JW), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (!q_empty),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lli_back #(.CoordBits(COORD_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (!q_empty),
    .job_i          (job_out),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ----- hdl/lli_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lli_front
// Accepts a line pair, forms the cross products d and na, classifies it.
// ----------------------------------------------------------------------------
module lli_front import lli_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire lli_in_t                        cmd_i,
  input  wire logic [SNAP_W-1:0]              snap_i,
  input  wire logic                           q_full_i,
  output logic                                push_o,
  output logic [8*CoordBits+9:0]              job_o,
  output logic                                busy_o
);

  localparam int unsigned C  = CoordBits;
  localparam int unsigned DW = C + 1;
  localparam int unsigned PW = 2 * C + 2;
  localparam int unsigned XW = 2 * C + 3;
  localparam int unsigned CW = ((XW > SNAP_W) ? XW : SNAP_W) + 1;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [C-1:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

  logic signed [C-1:0]  s1_ax_q, s1_ay_q;
  logic signed [DW-1:0] s1_adx_q, s1_ady_q, s1_bdx_q, s1_bdy_q, s1_ex_q, s1_ey_q;

  logic signed [C-1:0]  s2_ax_q, s2_ay_q;
  logic signed [DW-1:0] s2_adx_q, s2_ady_q;
  logic signed [PW-1:0] s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;

  logic signed [C-1:0]  s3_ax_q, s3_ay_q;
  logic signed [DW-1:0] s3_adx_q, s3_ady_q;
  logic signed [XW-1:0] s3_d_q, s3_na_q;

  logic signed [C-1:0]  s4_ax_q, s4_ay_q;
  logic signed [DW-1:0] s4_adx_q, s4_ady_q;
  logic signed [XW-1:0] s4_d_q, s4_na_q;
  outcome_e             s4_kind_q;

  logic signed [CW-1:0] snap_s, d_s, na_s;
  logic                 d_par, na_zero;
  outcome_e             kind_d;

  assign adv    = !(v4_q && q_full_i);
  assign busy_o = !adv;
  assign push_o = v4_q && !q_full_i;

  assign ax1 = cmd_i.line_a_start_x[C-1:0];
  assign ay1 = cmd_i.line_a_start_y[C-1:0];
  assign ax2 = cmd_i.line_a_end_x[C-1:0];
  assign ay2 = cmd_i.line_a_end_y[C-1:0];
  assign bx1 = cmd_i.line_b_start_x[C-1:0];
  assign by1 = cmd_i.line_b_start_y[C-1:0];
  assign bx2 = cmd_i.line_b_end_x[C-1:0];
  assign by2 = cmd_i.line_b_end_y[C-1:0];

  assign snap_s  = signed'(CW'(snap_i));
  assign d_s     = CW'(s3_d_q);
  assign na_s    = CW'(s3_na_q);
  assign d_par   = (s3_d_q == '0) || ((d_s < snap_s) && (d_s > -snap_s));
  assign na_zero = (na_s < snap_s) && (na_s > -snap_s);

  always_comb begin
    if (!d_par) begin
      kind_d = OUT_SINGLE;
    end else if (na_zero) begin
      kind_d = OUT_COINCIDENT;
    end else begin
      kind_d = OUT_PARALLEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ax_q  <= ax1;
      s1_ay_q  <= ay1;
      s1_adx_q <= DW'(ax2) - DW'(ax1);
      s1_ady_q <= DW'(ay2) - DW'(ay1);
      s1_bdx_q <= DW'(bx2) - DW'(bx1);
      s1_bdy_q <= DW'(by2) - DW'(by1);
      s1_ex_q  <= DW'(ax1) - DW'(bx1);
      s1_ey_q  <= DW'(ay1) - DW'(by1);

      s2_ax_q  <= s1_ax_q;
      s2_ay_q  <= s1_ay_q;
      s2_adx_q <= s1_adx_q;
      s2_ady_q <= s1_ady_q;
      s2_p1_q  <= s1_bdy_q * s1_adx_q;
      s2_p2_q  <= s1_bdx_q * s1_ady_q;
      s2_p3_q  <= s1_bdx_q * s1_ey_q;
      s2_p4_q  <= s1_bdy_q * s1_ex_q;

      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_adx_q <= s2_adx_q;
      s3_ady_q <= s2_ady_q;
      s3_d_q   <= XW'(s2_p1_q) - XW'(s2_p2_q);
      s3_na_q  <= XW'(s2_p3_q) - XW'(s2_p4_q);

      s4_ax_q   <= s3_ax_q;
      s4_ay_q   <= s3_ay_q;
      s4_adx_q  <= s3_adx_q;
      s4_ady_q  <= s3_ady_q;
      s4_d_q    <= s3_d_q;
      s4_na_q   <= s3_na_q;
      s4_kind_q <= kind_d;
    end
  end

  assign job_o = {s4_kind_q, s4_d_q, s4_na_q, s4_adx_q, s4_ady_q, s4_ax_q, s4_ay_q};

endmodule
`default_nettype wire

// ----- hdl/lli_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lli_queue
// Short register queue between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module lli_queue import lli_pkg::*; #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);
  localparam logic [NW-1:0] FULL = NW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;

  assign full_o  = (cnt_q == FULL);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL) else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- hdl/lli_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lli_back
// Projects na*delta/d onto both axes with a pipelined restoring divider,
// then saturates and registers the result transaction.
// ----------------------------------------------------------------------------
module lli_back import lli_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire logic [8*CoordBits+9:0]  job_i,
  output logic                         result_valid_o,
  output lli_out_t                     result_o
);

  localparam int unsigned C    = CoordBits;
  localparam int unsigned DW   = C + 1;
  localparam int unsigned XW   = 2 * C + 3;
  localparam int unsigned PRW  = XW + DW;
  localparam int unsigned RW   = C + 3;
  localparam int unsigned O_NA = 2 * C + 2 * DW;
  localparam int unsigned O_D  = O_NA + XW;
  localparam int unsigned O_K  = O_D + XW;
  localparam logic signed [RW-1:0] MAXV = RW'((64'd1 << (C - 1)) - 64'd1);
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
  localparam logic [C:0]  QSAT = (C + 1)'(1) << C;

  typedef struct packed {
    outcome_e            kind;
    logic                negx;
    logic                negy;
    logic                ovfx;
    logic                ovfy;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
  } side_t;

  logic signed [C-1:0]  j_ax, j_ay;
  logic signed [DW-1:0] j_adx, j_ady;
  logic signed [XW-1:0] j_na, j_d;
  outcome_e             j_kind;

  logic                 b1_v_q, b2_v_q, b3_v_q;
  side_t                b1_side_q, b2_side_q, b3_side_q;
  logic [XW-1:0]        b1_mna_q, b1_md_q, b2_md_q, b3_md_q;
  logic [DW-1:0]        b1_mdx_q, b1_mdy_q;
  logic [2*C:0]         b2_plx_q, b2_pmx_q, b2_ply_q, b2_pmy_q;
  logic [XW-2*C+DW-1:0] b2_phx_q, b2_phy_q;
  logic [PRW-1:0]       b3_prx_q, b3_pry_q;

  logic                 vld_q  [C+1];
  side_t                side_q [C+1];
  logic [XW-1:0]        md_q   [C+1];
  logic [XW-1:0]        remx_q [C+1];
  logic [XW-1:0]        remy_q [C+1];
  logic [C-1:0]         lowx_q [C+1];
  logic [C-1:0]         lowy_q [C+1];
  logic [C-1:0]         qtx_q  [C+1];
  logic [C-1:0]         qty_q  [C+1];

  logic                 ovfx, ovfy;
  side_t                side0;
  logic [C:0]           qmx, qmy;
  logic signed [RW-1:0] sumx, sumy, rx, ry;
  logic                 clipx, clipy;
  side_t                fs;
  lli_out_t             res_d, res_q;
  logic                 res_v_q;

  assign j_ay   = job_i[C-1:0];
  assign j_ax   = job_i[2*C-1:C];
  assign j_ady  = job_i[2*C+DW-1:2*C];
  assign j_adx  = job_i[2*C+2*DW-1:2*C+DW];
  assign j_na   = job_i[O_NA+XW-1:O_NA];
  assign j_d    = job_i[O_D+XW-1:O_D];
  assign j_kind = outcome_e'(job_i[O_K+1:O_K]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      b1_v_q <= valid_i;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      vld_q[0] <= b3_v_q;
    end
  end

  assign ovfx = b3_prx_q[PRW-1:C] >= (XW + 1)'(b3_md_q);
  assign ovfy = b3_pry_q[PRW-1:C] >= (XW + 1)'(b3_md_q);

  always_comb begin
    side0      = b3_side_q;
    side0.ovfx = ovfx;
    side0.ovfy = ovfy;
  end

  always_ff @(posedge clk_i) begin
    b1_side_q.kind <= j_kind;
    b1_side_q.negx <= j_na[XW-1] ^ j_adx[DW-1] ^ j_d[XW-1];
    b1_side_q.negy <= j_na[XW-1] ^ j_ady[DW-1] ^ j_d[XW-1];
    b1_side_q.ovfx <= 1'b0;
    b1_side_q.ovfy <= 1'b0;
    b1_side_q.sx   <= j_ax;
    b1_side_q.sy   <= j_ay;
    b1_mna_q <= j_na[XW-1] ? (~j_na + XW'(1)) : j_na;
    b1_md_q  <= j_d[XW-1] ? (~j_d + XW'(1)) : j_d;
    b1_mdx_q <= j_adx[DW-1] ? (~j_adx + DW'(1)) : j_adx;
    b1_mdy_q <= j_ady[DW-1] ? (~j_ady + DW'(1)) : j_ady;

    b2_side_q <= b1_side_q;
    b2_md_q   <= b1_md_q;
    b2_plx_q  <= b1_mna_q[C-1:0] * b1_mdx_q;
    b2_pmx_q  <= b1_mna_q[2*C-1:C] * b1_mdx_q;
    b2_phx_q  <= b1_mna_q[XW-1:2*C] * b1_mdx_q;
    b2_ply_q  <= b1_mna_q[C-1:0] * b1_mdy_q;
    b2_pmy_q  <= b1_mna_q[2*C-1:C] * b1_mdy_q;
    b2_phy_q  <= b1_mna_q[XW-1:2*C] * b1_mdy_q;

    b3_side_q <= b2_side_q;
    b3_md_q   <= b2_md_q;
    b3_prx_q  <= PRW'(b2_plx_q) + (PRW'(b2_pmx_q) << C) + (PRW'(b2_phx_q) << (2 * C));
    b3_pry_q  <= PRW'(b2_ply_q) + (PRW'(b2_pmy_q) << C) + (PRW'(b2_phy_q) << (2 * C));

    side_q[0]      <= side0;
    md_q[0]        <= b3_md_q;
    remx_q[0]      <= ovfx ? '0 : b3_prx_q[C+XW-1:C];
    remy_q[0]      <= ovfy ? '0 : b3_pry_q[C+XW-1:C];
    lowx_q[0]      <= b3_prx_q[C-1:0];
    lowy_q[0]      <= b3_pry_q[C-1:0];
    qtx_q[0]       <= '0;
    qty_q[0]       <= '0;
  end

  for (genvar k = 1; k <= C; k++) begin : g_div
    logic [XW:0] trx, try_w;
    logic        gex, gey;

    assign trx   = {remx_q[k-1], lowx_q[k-1][C-1]};
    assign try_w = {remy_q[k-1], lowy_q[k-1][C-1]};
    assign gex   = trx >= {1'b0, md_q[k-1]};
    assign gey   = try_w >= {1'b0, md_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
      md_q[k]   <= md_q[k-1];
      remx_q[k] <= gex ? XW'(trx - {1'b0, md_q[k-1]}) : trx[XW-1:0];
      remy_q[k] <= gey ? XW'(try_w - {1'b0, md_q[k-1]}) : try_w[XW-1:0];
      lowx_q[k] <= lowx_q[k-1] << 1;
      lowy_q[k] <= lowy_q[k-1] << 1;
      qtx_q[k]  <= (qtx_q[k-1] << 1) | C'(gex);
      qty_q[k]  <= (qty_q[k-1] << 1) | C'(gey);
    end
  end

  assign fs   = side_q[C];
  assign qmx  = fs.ovfx ? QSAT : {1'b0, qtx_q[C]};
  assign qmy  = fs.ovfy ? QSAT : {1'b0, qty_q[C]};
  assign sumx = RW'(fs.sx) + (fs.negx ? -signed'(RW'(qmx)) : signed'(RW'(qmx)));
  assign sumy = RW'(fs.sy) + (fs.negy ? -signed'(RW'(qmy)) : signed'(RW'(qmy)));

  always_comb begin
    clipx = 1'b0;
    clipy = 1'b0;
    rx    = sumx;
    ry    = sumy;
    if (sumx > MAXV) begin
      rx    = MAXV;
      clipx = 1'b1;
    end else if (sumx < MINV) begin
      rx    = MINV;
      clipx = 1'b1;
    end
    if (sumy > MAXV) begin
      ry    = MAXV;
      clipy = 1'b1;
    end else if (sumy < MINV) begin
      ry    = MINV;
      clipy = 1'b1;
    end
  end

  always_comb begin
    res_d.outcome = fs.kind;
    unique case (fs.kind)
      OUT_SINGLE: begin
        res_d.cross_x = 32'(signed'(rx[C-1:0]));
        res_d.cross_y = 32'(signed'(ry[C-1:0]));
        res_d.clipped = clipx | clipy;
      end
      OUT_COINCIDENT: begin
        res_d.cross_x = 32'(fs.sx);
        res_d.cross_y = 32'(fs.sy);
        res_d.clipped = 1'b0;
      end
      default: begin
        res_d.cross_x = '0;
        res_d.cross_y = '0;
        res_d.clipped = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= vld_q[C];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  a_clip_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.outcome != OUT_SINGLE) |-> !result_o.clipped)
    else $error("clip flag on a non-intersecting result");
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.outcome == OUT_PARALLEL)
      |-> (result_o.cross_x == '0 && result_o.cross_y == '0))
    else $error("parallel result carries a point");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> ##(C + 4) result_valid_o)
    else $error("back pipeline dropped a transaction");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line intersection testbench
// Streams line pairs into line_line_intersection under several snapping
// thresholds and sender idle rates. A directed table covers corners,
// coincident, parallel and saturating cases. Random pairs follow. Every
// result is checked field by field against the table or a wide-int model.
// ----------------------------------------------------------------------------
module testbench;
  import lli_pkg::*;

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam int unsigned SEG_ITEMS = 300;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    lli_in_t  cmd;
    bit       typed;
    lli_out_t want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  lli_in_t           cmd_i;
  logic              cfg_we_i;
  logic [SNAP_W-1:0] cfg_wdata_i;
  logic              result_valid_o;
  lli_out_t          result_o;

  logic [SNAP_W-1:0] snap_cur;
  lli_out_t          pending_q[$];
  int unsigned       idle_pct;
  int unsigned       err_cnt;
  stim_row_t         rows[$];

  line_line_intersection uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [31:0] project_axis(
      logic signed [127:0] origin, logic signed [127:0] delta,
      logic signed [127:0] na, logic signed [127:0] den, inout bit clip);
    logic signed [127:0] quot;
    logic signed [127:0] sum;
    bit neg;
    neg  = (na < 0) ^ (delta < 0) ^ (den < 0);
    quot = ((na < 0 ? -na : na) * (delta < 0 ? -delta : delta)) / (den < 0 ? -den : den);
    if (quot > (128'sd1 <<< 40)) quot = 128'sd1 <<< 40;
    sum = origin + (neg ? -quot : quot);
    if (sum > CMAX) begin
      sum  = CMAX;
      clip = 1'b1;
    end
    if (sum < CMIN) begin
      sum  = CMIN;
      clip = 1'b1;
    end
    return sum[31:0];
  endfunction

  function automatic lli_out_t predict_crossing(lli_in_t c, logic [SNAP_W-1:0] snap);
    logic signed [127:0] ax1, ay1, adx, ady, bx1, by1, bdx, bdy, den, na, thr;
    lli_out_t r;
    bit clip;
    ax1  = c.line_a_start_x;
    ay1  = c.line_a_start_y;
    bx1  = c.line_b_start_x;
    by1  = c.line_b_start_y;
    adx  = 128'(c.line_a_end_x) - ax1;
    ady  = 128'(c.line_a_end_y) - ay1;
    bdx  = 128'(c.line_b_end_x) - bx1;
    bdy  = 128'(c.line_b_end_y) - by1;
    den  = bdy * adx - bdx * ady;
    na   = bdx * (ay1 - by1) - bdy * (ax1 - bx1);
    thr  = $signed({65'd0, snap});
    clip = 1'b0;
    r    = '{cross_x: '0, cross_y: '0, outcome: OUT_PARALLEL, clipped: 1'b0};
    if (den == 0 || (den < 0 ? -den : den) < thr) begin
      if ((na < 0 ? -na : na) < thr) begin
        r.cross_x = c.line_a_start_x;
        r.cross_y = c.line_a_start_y;
        r.outcome = OUT_COINCIDENT;
      end
    end else begin
      r.cross_x = project_axis(ax1, adx, na, den, clip);
      r.cross_y = project_axis(ay1, ady, na, den, clip);
      r.outcome = OUT_SINGLE;
      r.clipped = clip;
    end
    return r;
  endfunction

  function automatic lli_in_t random_lines();
    lli_in_t c;
    logic signed [31:0] corners[6];
    logic signed [31:0] dx, dy, ox, oy;
    int k, m;
    corners = '{CMIN, CMAX, 32'sd0, -32'sd1, 32'sd1, 32'sh0001_0000};
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: ;
      3: begin
        c.line_a_start_x = $signed($urandom_range(128)) - 64;
        c.line_a_start_y = $signed($urandom_range(128)) - 64;
        c.line_a_end_x   = $signed($urandom_range(128)) - 64;
        c.line_a_end_y   = $signed($urandom_range(128)) - 64;
        c.line_b_start_x = $signed($urandom_range(128)) - 64;
        c.line_b_start_y = $signed($urandom_range(128)) - 64;
        c.line_b_end_x   = $signed($urandom_range(128)) - 64;
        c.line_b_end_y   = $signed($urandom_range(128)) - 64;
      end
      4: begin
        dx = $signed($urandom_range(2048)) - 1024;
        dy = $signed($urandom_range(2048)) - 1024;
        ox = $signed($urandom_range(64)) - 32;
        oy = $signed($urandom_range(64)) - 32;
        c.line_a_end_x   = c.line_a_start_x + dx;
        c.line_a_end_y   = c.line_a_start_y + dy;
        c.line_b_start_x = c.line_a_start_x + ox;
        c.line_b_start_y = c.line_a_start_y + oy;
        c.line_b_end_x   = c.line_b_start_x + dx * 3;
        c.line_b_end_y   = c.line_b_start_y + dy * 3;
      end
      5: begin
        dx = $signed($urandom_range(512)) - 256;
        dy = $signed($urandom_range(512)) - 256;
        k  = $urandom_range(20) - 10;
        m  = $urandom_range(20) - 10;
        c.line_a_start_x = $signed($urandom_range(1 << 24)) - (1 << 23);
        c.line_a_start_y = $signed($urandom_range(1 << 24)) - (1 << 23);
        c.line_a_end_x   = c.line_a_start_x + dx;
        c.line_a_end_y   = c.line_a_start_y + dy;
        c.line_b_start_x = c.line_a_start_x + dx * k;
        c.line_b_start_y = c.line_a_start_y + dy * k;
        c.line_b_end_x   = c.line_a_start_x + dx * m;
        c.line_b_end_y   = c.line_a_start_y + dy * m;
      end
      6: begin
        if ($urandom_range(1)) c.line_a_start_x = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_a_start_y = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_a_end_x   = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_a_end_y   = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_b_start_x = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_b_start_y = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_b_end_x   = corners[$urandom_range(5)];
        if ($urandom_range(1)) c.line_b_end_y   = corners[$urandom_range(5)];
      end
      default: begin
        c.line_a_start_x = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_a_start_y = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_a_end_x   = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_a_end_y   = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_b_start_x = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_b_start_y = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_b_end_x   = $signed($urandom_range(1 << 21)) - (1 << 20);
        c.line_b_end_y   = $signed($urandom_range(1 << 21)) - (1 << 20);
      end
    endcase
    return c;
  endfunction

  task automatic send_lines(lli_in_t c, bit typed, lli_out_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_q.push_back(typed ? want : predict_crossing(c, snap_cur));
  endtask

  task automatic write_snap(logic [SNAP_W-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    snap_cur     = value;
  endtask

  always @(posedge clk_i) begin
    lli_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (result_o.cross_x !== want.cross_x) begin
          $error("cross_x: expected %0d, got %0d", want.cross_x, result_o.cross_x);
          err_cnt++;
        end
        if (result_o.cross_y !== want.cross_y) begin
          $error("cross_y: expected %0d, got %0d", want.cross_y, result_o.cross_y);
          err_cnt++;
        end
        if (result_o.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, result_o.outcome);
          err_cnt++;
        end
        if (result_o.clipped !== want.clipped) begin
          $error("clipped: expected %0d, got %0d", want.clipped, result_o.clipped);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [SNAP_W-1:0] snaps[6];
    lli_out_t none;
    int unsigned wait_cnt;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    snap_cur    = SNAP_RESET;
    idle_pct    = 7;
    err_cnt     = 0;
    none        = '0;
    snaps = '{63'd1, {SNAP_W{1'b1}}, 63'd1 << 32, 63'd1 << 16,
              63'($urandom_range(1000, 1)), 63'({$urandom, $urandom}) | 63'd1};

    rows.push_back('{'0, 1'b1, '{32'sd0, 32'sd0, OUT_COINCIDENT, 1'b0}});
    rows.push_back('{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}, 1'b1,
                     '{CMIN, CMAX, OUT_COINCIDENT, 1'b0}});
    rows.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1,
                     '{CMAX, CMAX, OUT_COINCIDENT, 1'b0}});
    rows.push_back('{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1,
                     '{CMIN, CMIN, OUT_COINCIDENT, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1},
                     1'b1, '{32'sd0, 32'sd0, OUT_PARALLEL, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd0, 32'sd2, 32'sd0, 32'sd1, -32'sd1, 32'sd1, 32'sd1},
                     1'b1, '{32'sd1, 32'sd0, OUT_SINGLE, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd0, 32'sd2, 32'sd1, 32'sd0, CMAX, 32'sd1, CMAX},
                     1'b1, '{CMAX, CMAX, OUT_SINGLE, 1'b1}});
    rows.push_back('{'{32'sd0, 32'sd0, -32'sd2, -32'sd1, 32'sd0, CMIN, 32'sd1, CMIN},
                     1'b1, '{CMIN, CMIN, OUT_SINGLE, 1'b1}});
    rows.push_back('{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, none});
    rows.push_back('{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, none});
    rows.push_back('{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
                       32'sh0001_0000, -32'sh0001_0000, -32'sh0003_0000, 32'sh0002_8000},
                     1'b0, none});
    rows.push_back('{'{-32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1},
                     1'b0, none});
    rows.push_back('{'{32'sh0001_0000, 32'sd0, 32'sh0003_0000, 32'sh0001_0000,
                       32'sd0, 32'sh0002_0000, 32'sh0004_0000, 32'sd0}, 1'b0, none});

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_lines(rows[i].cmd, rows[i].typed, rows[i].want);

    for (int seg = 0; seg < 6; seg++) begin
      write_snap(snaps[seg]);
      idle_pct = (seg < 2) ? 7 : (seg < 4) ? 64 : 0;
      for (int n = 0; n < SEG_ITEMS; n++) send_lines(random_lines(), 1'b0, none);
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 10_000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lli_pkg.sv
hdl/lli_front.sv
hdl/lli_queue.sv
hdl/lli_back.sv
hdl/line_line_intersection.sv
bench/testbench.sv
